// File: src/mrm_pkg.sv
// shared types, codes and the crc-16 byte step for the modbus rtu master
// no dependencies; used by the top level and the checker
`default_nettype none

package mrm_pkg;

    // default depth of the response frame buffer
    localparam int BUFFER_BYTES_DEF = 64;

    // stream payload widths
    localparam int IN_DATA_W  = 64;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 2;

    // configuration port
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_RESPONSE_TIMEOUT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CHAR_GAP         = 1'd1;
    localparam logic [15:0] RESPONSE_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] CHAR_GAP_RST         = 16'd4;

    // input item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // transaction status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CRC     = 3'd1;
    localparam logic [2:0] ST_BAD_ID  = 3'd2;
    localparam logic [2:0] ST_ECHO    = 3'd3;
    localparam logic [2:0] ST_NO_RESP = 3'd4;

    // function codes whose response echoes the request
    localparam logic [7:0] FC_WRITE_COIL = 8'h05;
    localparam logic [7:0] FC_WRITE_REG  = 8'h06;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [6:0] response_length;
        logic       last;
    } t_result;

    // reflected crc-16 over one byte, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/mrm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module mrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/modbus_rtu_master_transaction_top.sv
// modbus rtu master, one request/response exchange: framing, turnaround, rx buffer
// depends on mrm_pkg and mrm_ram
// received byte and timer tick: their result (if any) is written into the output queue on acceptance
// buffer read: the frame ram read data is registered, and the result is pushed from the S_RD state
// start: the request crc runs one byte per cycle over six bytes
// turnaround expiry tick starts transmit, then 8 transmit results go out one per cycle while the output queue has room
// reset is synchronous active low; the frame ram needs no clearing pass
`default_nettype none

module modbus_rtu_master_transaction_top #(
    parameter int BUFFER_BYTES = mrm_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave side: input items
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: slave_address, function_code, start_address, access_count, rx_byte,
    //        read_index, zero pad
    input  wire logic [mrm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: mode
    input  wire logic [mrm_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    // master side: result items
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // tdata: data_byte, status, response_length, zero pad
    output logic      [mrm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // tuser: kind
    output logic      [mrm_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    output logic                                 o_m_axis_tlast,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [mrm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [mrm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    import mrm_pkg::*;

    // buffer address and received-count widths
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);

    // sequencer states
    localparam logic [1:0] S_RUN = 2'd0;  // taking items
    localparam logic [1:0] S_CRC = 2'd1;  // request crc, one byte per cycle
    localparam logic [1:0] S_TX  = 2'd2;  // emitting the eight request bytes
    localparam logic [1:0] S_RD  = 2'd3;  // waiting on frame ram read data

    // exchange phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TURN = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_RECV = 2'd3;

    // configuration registers
    logic [15:0] r_resp_timeout;
    logic [15:0] r_char_gap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resp_timeout <= RESPONSE_TIMEOUT_RST;
            r_char_gap     <= CHAR_GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RESPONSE_TIMEOUT: r_resp_timeout <= i_cfg_wdata;
                REG_CHAR_GAP:         r_char_gap     <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // input field unpacking
    logic [1:0]  w_mode;
    logic [7:0]  w_slave;
    logic [7:0]  w_fc;
    logic [15:0] w_addr;
    logic [15:0] w_cnt;
    logic [7:0]  w_rx;
    logic [5:0]  w_idx;

    assign w_mode  = i_s_axis_tuser;
    assign w_slave = i_s_axis_tdata[7:0];
    assign w_fc    = i_s_axis_tdata[15:8];
    assign w_addr  = i_s_axis_tdata[31:16];
    assign w_cnt   = i_s_axis_tdata[47:32];
    assign w_rx    = i_s_axis_tdata[55:48];
    assign w_idx   = i_s_axis_tdata[61:56];

    // control and exchange state
    logic [1:0]    r_state,   n_state;
    logic [2:0]    r_step,    n_step;
    logic [1:0]    r_phase,   n_phase;
    logic [15:0]   r_timer,   n_timer;
    logic [15:0]   r_req_crc, n_req_crc;
    logic [15:0]   r_run_crc, n_run_crc;
    logic [15:0]   r_lag_crc, n_lag_crc;
    logic [15:0]   r_body_crc, n_body_crc;
    logic [CW-1:0] r_count,   n_count;
    logic          r_rd_oob,  n_rd_oob;

    // request fields, payload only
    logic [7:0]  r_slave, n_slave;
    logic [7:0]  r_fc,    n_fc;
    logic [15:0] r_addr,  n_addr;
    logic [15:0] r_cnt,   n_cnt;

    // first two and last two response bytes, kept beside the ram for the status check
    logic [7:0] r_first0, n_first0;
    logic [7:0] r_first1, n_first1;
    logic [7:0] r_last1,  n_last1;
    logic [7:0] r_last2,  n_last2;

    // output queue, two entries
    t_result     r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_qcnt;
    logic        w_full;
    logic        w_push;
    t_result     w_res;
    logic        w_pop;

    // frame ram
    logic          w_ram_we;
    logic          w_ram_re;
    logic [AW-1:0] w_ram_raddr;
    logic [7:0]    w_ram_q;

    logic          w_accept;
    logic [7:0]    w_req_byte;
    logic [CW-1:0] w_cnt_inc;

    assign w_full          = (r_qcnt == 2'd2);
    assign o_s_axis_tready = (r_state == S_RUN) && !w_full;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cnt_inc       = r_count + CW'(1);
    assign w_ram_raddr     = AW'(w_idx);

    // request byte k in send order, crc low byte first
    always_comb begin
        unique case (r_step)
            3'd0: w_req_byte = r_slave;
            3'd1: w_req_byte = r_fc;
            3'd2: w_req_byte = r_addr[15:8];
            3'd3: w_req_byte = r_addr[7:0];
            3'd4: w_req_byte = r_cnt[15:8];
            3'd5: w_req_byte = r_cnt[7:0];
            3'd6: w_req_byte = r_req_crc[7:0];
            3'd7: w_req_byte = r_req_crc[15:8];
            default: w_req_byte = 8'h00;
        endcase
    end

    // response length saturates at the field's range
    function automatic logic [6:0] f_len(input logic [CW-1:0] n);
        logic [15:0] wide;
        wide = 16'(n);
        return (wide > 16'd127) ? 7'd127 : wide[6:0];
    endfunction

    // done status, checks in priority order
    function automatic logic [2:0] f_status(
        input logic [CW-1:0] n,
        input logic [7:0]    first0,
        input logic [7:0]    first1,
        input logic [7:0]    last1,
        input logic [7:0]    last2,
        input logic [15:0]   body,
        input logic [7:0]    slave,
        input logic [7:0]    fc,
        input logic [15:0]   req_crc
    );
        logic [2:0] st;
        if (16'(n) < 16'd3) begin
            st = ST_CRC;
        end else if ({last1, last2} != body) begin
            st = ST_CRC;
        end else if (first0 != slave || first1 != fc) begin
            st = ST_BAD_ID;
        end else if ((fc == FC_WRITE_COIL || fc == FC_WRITE_REG) && req_crc != body) begin
            st = ST_ECHO;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_phase    = r_phase;
        n_timer    = r_timer;
        n_req_crc  = r_req_crc;
        n_run_crc  = r_run_crc;
        n_lag_crc  = r_lag_crc;
        n_body_crc = r_body_crc;
        n_count    = r_count;
        n_rd_oob   = r_rd_oob;
        n_slave    = r_slave;
        n_fc       = r_fc;
        n_addr     = r_addr;
        n_cnt      = r_cnt;
        n_first0   = r_first0;
        n_first1   = r_first1;
        n_last1    = r_last1;
        n_last2    = r_last2;
        w_push     = 1'b0;
        w_res      = '0;
        w_ram_we   = 1'b0;
        w_ram_re   = 1'b0;

        unique case (r_state)
            S_RUN: begin
                if (w_accept) begin
                    unique case (w_mode)
                        MODE_START: begin
                            // a start abandons any exchange in flight
                            n_slave    = w_slave;
                            n_fc       = w_fc;
                            n_addr     = w_addr;
                            n_cnt      = w_cnt;
                            n_req_crc  = crc_byte(CRC_INIT, w_slave);
                            n_step     = 3'd1;
                            n_state    = S_CRC;
                            n_run_crc  = CRC_INIT;
                            n_lag_crc  = CRC_INIT;
                            n_body_crc = CRC_INIT;
                            n_count    = '0;
                            n_timer    = r_resp_timeout;
                            n_phase    = PH_TURN;
                        end
                        MODE_BYTE: begin
                            if (r_phase == PH_WAIT || r_phase == PH_RECV) begin
                                w_ram_we = (16'(r_count) < 16'(BUFFER_BYTES));
                                if (r_count == CW'(0)) begin
                                    n_first0 = w_rx;
                                end
                                if (r_count == CW'(1)) begin
                                    n_first1 = w_rx;
                                end
                                n_last2    = r_last1;
                                n_last1    = w_rx;
                                // body crc trails the running crc by two bytes
                                n_body_crc = r_lag_crc;
                                n_lag_crc  = r_run_crc;
                                n_run_crc  = crc_byte(r_run_crc, w_rx);
                                n_count    = w_cnt_inc;
                                n_timer    = r_char_gap;
                                n_phase    = PH_RECV;
                                // the byte that fills the buffer closes the frame
                                if (16'(w_cnt_inc) >= 16'(BUFFER_BYTES)) begin
                                    w_push = 1'b1;
                                    w_res.kind   = KIND_DONE;
                                    w_res.status = f_status(w_cnt_inc, n_first0, n_first1,
                                                            n_last1, n_last2, n_body_crc,
                                                            r_slave, r_fc, r_req_crc);
                                    w_res.response_length = f_len(w_cnt_inc);
                                    w_res.last = 1'b1;
                                    n_phase = PH_IDLE;
                                    n_timer = '0;
                                end
                            end
                        end
                        MODE_TICK: begin
                            if (r_phase != PH_IDLE) begin
                                if (r_timer <= 16'd1) begin
                                    n_timer = '0;
                                    unique case (r_phase)
                                        PH_TURN: begin
                                            n_state = S_TX;
                                            n_step  = 3'd0;
                                            n_timer = r_resp_timeout;
                                            n_phase = PH_WAIT;
                                        end
                                        PH_WAIT: begin
                                            w_push = 1'b1;
                                            w_res.kind   = KIND_DONE;
                                            w_res.status = ST_NO_RESP;
                                            w_res.last   = 1'b1;
                                            n_phase = PH_IDLE;
                                        end
                                        PH_RECV: begin
                                            w_push = 1'b1;
                                            w_res.kind   = KIND_DONE;
                                            w_res.status = f_status(r_count, r_first0, r_first1,
                                                                    r_last1, r_last2, r_body_crc,
                                                                    r_slave, r_fc, r_req_crc);
                                            w_res.response_length = f_len(r_count);
                                            w_res.last = 1'b1;
                                            n_phase = PH_IDLE;
                                        end
                                        default: ;
                                    endcase
                                end else begin
                                    n_timer = r_timer - 16'd1;
                                end
                            end
                        end
                        MODE_READ: begin
                            w_ram_re = 1'b1;
                            n_rd_oob = !(16'(w_idx) < 16'(BUFFER_BYTES));
                            n_state  = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_CRC: begin
                n_req_crc = crc_byte(r_req_crc, w_req_byte);
                n_step    = r_step + 3'd1;
                if (r_step == 3'd5) begin
                    n_state = S_RUN;
                end
            end
            S_TX: begin
                if (!w_full) begin
                    w_push = 1'b1;
                    w_res.kind      = KIND_TX;
                    w_res.data_byte = w_req_byte;
                    w_res.last      = (r_step == 3'd7);
                    n_step = r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RD: begin
                if (!w_full) begin
                    w_push = 1'b1;
                    w_res.kind            = KIND_READ;
                    w_res.data_byte       = r_rd_oob ? 8'h00 : w_ram_q;
                    w_res.response_length = f_len(r_count);
                    w_res.last            = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_RUN;
            r_step     <= '0;
            r_phase    <= PH_IDLE;
            r_timer    <= '0;
            r_req_crc  <= '0;
            r_run_crc  <= CRC_INIT;
            r_lag_crc  <= CRC_INIT;
            r_body_crc <= '0;
            r_count    <= '0;
            r_rd_oob   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_phase    <= n_phase;
            r_timer    <= n_timer;
            r_req_crc  <= n_req_crc;
            r_run_crc  <= n_run_crc;
            r_lag_crc  <= n_lag_crc;
            r_body_crc <= n_body_crc;
            r_count    <= n_count;
            r_rd_oob   <= n_rd_oob;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_slave  <= n_slave;
        r_fc     <= n_fc;
        r_addr   <= n_addr;
        r_cnt    <= n_cnt;
        r_first0 <= n_first0;
        r_first1 <= n_first1;
        r_last1  <= n_last1;
        r_last2  <= n_last2;
    end

    // response frame buffer
    mrm_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(r_count)),
        .i_wdata (w_rx),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_q)
    );

    // output queue lets the next item in while a result waits
    assign w_pop = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_qcnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_qcnt <= r_qcnt + 2'd1;
                2'b01:   r_qcnt <= r_qcnt - 2'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_res;
        end
    end

    assign o_m_axis_tvalid = (r_qcnt != 2'd0);
    assign o_m_axis_tuser  = r_q[r_rp].kind;
    assign o_m_axis_tlast  = r_q[r_rp].last;
    assign o_m_axis_tdata  = {6'b0, r_q[r_rp].response_length,
                              r_q[r_rp].status, r_q[r_rp].data_byte};

endmodule

`default_nettype wire

// File: src/mrm_checker.sv
// port-level assertions for the modbus rtu master, bound to the top level
// depends on mrm_pkg
`default_nettype none

module mrm_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_axis_tvalid,
    input wire logic                            o_s_axis_tready,
    input wire logic [mrm_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    input wire logic                            o_m_axis_tvalid,
    input wire logic                            i_m_axis_tready,
    input wire logic [mrm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input wire logic [mrm_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    input wire logic                            o_m_axis_tlast
);

    import mrm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("output item changed while stalled");

    // done and read results are single-item runs
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == KIND_DONE || o_m_axis_tuser == KIND_READ)
            |-> o_m_axis_tlast)
        else $error("done or read item without last");

    // transmit bytes carry no status and no length
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_TX |-> o_m_axis_tdata[17:8] == 10'd0)
        else $error("transmit item with status or length");

    // the request crc is worked out after a start, no item is taken meanwhile
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser == MODE_START
            |=> !o_s_axis_tready)
        else $error("item taken during request crc");

endmodule

bind modbus_rtu_master_transaction_top mrm_checker u_mrm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
